### design/tcm_8psk_viterbi_decoder_defines.svh
// Assertion macros shared by the 8PSK trellis decoder RTL.
`ifndef TCM_8PSK_VITERBI_DECODER_DEFINES_SVH
`define TCM_8PSK_VITERBI_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define TCM8_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcm8 assertion failed");

// Condition in one cycle implies a result in the next.
`define TCM8_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcm8 assertion failed");

`else

`define TCM8_ASSERT(name, clk, rst_n, prop)
`define TCM8_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### design/tcm8_pkg.sv
// Shared constants, trellis tables and types of the 8PSK trellis decoder.
`default_nettype none

package tcm8_pkg;

    localparam int SAMPLE_WIDTH_DEF = 12;
    localparam int METRIC_WIDTH_DEF = 20;

    localparam int NUM_STATES = 4;
    localparam int NUM_INPUTS = 4;
    localparam int NUM_POINTS = 8;

    // Branch-metric queue depth, a power of two.
    localparam int Q_DEPTH = 2;

    // Scaled sqrt(1/2) with 32 fraction bits.
    localparam logic [31:0] DIAG_FRAC32 = 32'hB504F334;

    // Constellation point sent from state s on input u.
    localparam logic [2:0] POINT_TAB [NUM_STATES][NUM_INPUTS] = '{
        '{3'd0, 3'd2, 3'd4, 3'd6},
        '{3'd2, 3'd0, 3'd6, 3'd4},
        '{3'd1, 3'd3, 3'd5, 3'd7},
        '{3'd3, 3'd1, 3'd7, 3'd5}
    };

    // Incoming branches of each destination, in scan order (source, then input).
    localparam logic [1:0] CAND_SRC [NUM_STATES][4] = '{
        '{2'd0, 2'd0, 2'd1, 2'd1},
        '{2'd2, 2'd2, 2'd3, 2'd3},
        '{2'd0, 2'd0, 2'd1, 2'd1},
        '{2'd2, 2'd2, 2'd3, 2'd3}
    };

    localparam logic [1:0] CAND_IN [NUM_STATES][4] = '{
        '{2'd0, 2'd2, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd0, 2'd2},
        '{2'd1, 2'd3, 2'd1, 2'd3},
        '{2'd1, 2'd3, 2'd1, 2'd3}
    };

    // Coordinate sign codes of the constellation points.
    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } t_sign;

    localparam t_sign PT_RE_SIGN [NUM_POINTS] = '{
        SGN_POS, SGN_POS, SGN_ZERO, SGN_NEG, SGN_NEG, SGN_NEG, SGN_ZERO, SGN_POS
    };

    localparam t_sign PT_IM_SIGN [NUM_POINTS] = '{
        SGN_ZERO, SGN_POS, SGN_POS, SGN_POS, SGN_ZERO, SGN_NEG, SGN_NEG, SGN_NEG
    };

    localparam logic PT_IS_DIAG [NUM_POINTS] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
    };

    // Queue status seen by the back end and the input handshake.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

### design/tcm8_bm_front.sv
// Front end: squared Euclidean branch metrics of one sample to all eight points.
`default_nettype none

module tcm8_bm_front #(
    parameter int SAMPLE_WIDTH = tcm8_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0]                        i_sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0]                        i_sample_q,
    output logic [tcm8_pkg::NUM_POINTS*(SAMPLE_WIDTH+3)-1:0]           o_bm
);
    import tcm8_pkg::*;

    localparam int FRAC = SAMPLE_WIDTH - 2;
    localparam int DW   = SAMPLE_WIDTH + 1;
    localparam int BMW  = SAMPLE_WIDTH + 3;
    localparam int PW   = 2 * DW;

    localparam logic signed [DW-1:0] UNIT_C = DW'(1) << FRAC;
    localparam logic signed [DW-1:0] DIAG_C = DW'(DIAG_FRAC32 >> (32 - FRAC));

    logic signed [DW-1:0] w_si;
    logic signed [DW-1:0] w_sq;

    assign w_si = {i_sample_i[SAMPLE_WIDTH-1], i_sample_i};
    assign w_sq = {i_sample_q[SAMPLE_WIDTH-1], i_sample_q};

    always_comb begin
        logic signed [DW-1:0] mag;
        logic signed [DW-1:0] pr;
        logic signed [DW-1:0] pq;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic [PW-1:0]        sum;
        o_bm = '0;
        for (int p = 0; p < NUM_POINTS; p++) begin
            mag = PT_IS_DIAG[p] ? DIAG_C : UNIT_C;
            unique case (PT_RE_SIGN[p])
                SGN_POS: pr = mag;
                SGN_NEG: pr = -mag;
                default: pr = '0;
            endcase
            unique case (PT_IM_SIGN[p])
                SGN_POS: pq = mag;
                SGN_NEG: pq = -mag;
                default: pq = '0;
            endcase
            dx  = pr - w_si;
            dy  = pq - w_sq;
            px  = dx * dx;
            py  = dy * dy;
            // both squares are nonnegative and their sum stays below 2^(PW-1)
            sum = $unsigned(px) + $unsigned(py);
            o_bm[p*BMW +: BMW] = sum[FRAC+BMW-1:FRAC];
        end
    end

endmodule

`default_nettype wire

### design/tcm8_queue.sv
// Short FIFO of branch-metric sets between the front and back ends.
`default_nettype none

module tcm8_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output tcm8_pkg::t_q_stat      o_stat
);
    import tcm8_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];
    assign o_stat = '{full: (r_count == CNT_W'(Q_DEPTH)), empty: (r_count == '0)};

endmodule

`default_nettype wire

### design/tcm8_acs_back.sv
// Back end: add-compare-select, normalization and the registered result.
`default_nettype none

module tcm8_acs_back #(
    parameter int SAMPLE_WIDTH = tcm8_pkg::SAMPLE_WIDTH_DEF,
    parameter int METRIC_WIDTH = tcm8_pkg::METRIC_WIDTH_DEF
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire tcm8_pkg::t_q_stat                                 i_q_stat,
    input  wire logic [tcm8_pkg::NUM_POINTS*(SAMPLE_WIDTH+3)-1:0]  i_bm,
    output logic                                                   o_pop,
    output logic                                                   o_valid,
    input  wire logic                                              i_ready,
    output logic [1:0]                                             o_decoded_symbol,
    output logic [1:0]                                             o_best_state
);
    import tcm8_pkg::*;

    localparam int BMW  = SAMPLE_WIDTH + 3;
    localparam int SUMW = ((METRIC_WIDTH > BMW) ? METRIC_WIDTH : BMW) + 1;
    localparam logic [SUMW-1:0] MAX_S = SUMW'({METRIC_WIDTH{1'b1}});

    logic [METRIC_WIDTH-1:0] r_metric [NUM_STATES];
    logic [METRIC_WIDTH-1:0] n_metric [NUM_STATES];
    logic                    r_valid;
    logic [1:0]              r_sym;
    logic [1:0]              r_best;

    logic [METRIC_WIDTH-1:0] w_new_pm   [NUM_STATES];
    logic [1:0]              w_new_surv [NUM_STATES];
    logic [1:0]              w_best;
    logic [1:0]              w_sym;
    logic                    w_step;

    // Advance when a metric set waits and the output register is free.
    assign w_step = !i_q_stat.empty && (!r_valid || i_ready);

    // Per-destination select: pairwise tree, the earlier candidate wins ties.
    always_comb begin
        logic [SUMW-1:0]         sum;
        logic [METRIC_WIDTH-1:0] c  [4];
        logic [METRIC_WIDTH-1:0] m01;
        logic [METRIC_WIDTH-1:0] m23;
        logic [1:0]              u01;
        logic [1:0]              u23;
        for (int d = 0; d < NUM_STATES; d++) begin
            for (int k = 0; k < 4; k++) begin
                sum = SUMW'(r_metric[CAND_SRC[d][k]])
                    + SUMW'(i_bm[POINT_TAB[CAND_SRC[d][k]][CAND_IN[d][k]]*BMW +: BMW]);
                c[k] = (sum > MAX_S) ? {METRIC_WIDTH{1'b1}} : sum[METRIC_WIDTH-1:0];
            end
            if (c[1] < c[0]) begin
                m01 = c[1];
                u01 = CAND_IN[d][1];
            end else begin
                m01 = c[0];
                u01 = CAND_IN[d][0];
            end
            if (c[3] < c[2]) begin
                m23 = c[3];
                u23 = CAND_IN[d][3];
            end else begin
                m23 = c[2];
                u23 = CAND_IN[d][2];
            end
            if (m23 < m01) begin
                w_new_pm[d]   = m23;
                w_new_surv[d] = u23;
            end else begin
                w_new_pm[d]   = m01;
                w_new_surv[d] = u01;
            end
        end
    end

    // Best state, lowest index on ties, then normalize against its metric.
    always_comb begin
        logic [METRIC_WIDTH-1:0] m01;
        logic [METRIC_WIDTH-1:0] m23;
        logic [METRIC_WIDTH-1:0] lowest;
        logic [1:0]              b01;
        logic [1:0]              b23;
        b01 = (w_new_pm[1] < w_new_pm[0]) ? 2'd1 : 2'd0;
        m01 = (w_new_pm[1] < w_new_pm[0]) ? w_new_pm[1] : w_new_pm[0];
        b23 = (w_new_pm[3] < w_new_pm[2]) ? 2'd3 : 2'd2;
        m23 = (w_new_pm[3] < w_new_pm[2]) ? w_new_pm[3] : w_new_pm[2];
        if (m23 < m01) begin
            w_best = b23;
            lowest = m23;
        end else begin
            w_best = b01;
            lowest = m01;
        end
        for (int d = 0; d < NUM_STATES; d++) begin
            n_metric[d] = w_new_pm[d] - lowest;
        end
        w_sym = w_new_surv[w_best];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int d = 0; d < NUM_STATES; d++) begin
                r_metric[d] <= '0;
            end
        end else begin
            if (w_step) begin
                r_valid <= 1'b1;
                for (int d = 0; d < NUM_STATES; d++) begin
                    r_metric[d] <= n_metric[d];
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_sym  <= w_sym;
            r_best <= w_best;
        end
    end

    assign o_pop            = w_step;
    assign o_valid          = r_valid;
    assign o_decoded_symbol = r_sym;
    assign o_best_state     = r_best;

endmodule

`default_nettype wire

### design/tcm_8psk_viterbi_decoder.sv
// Four-state 8PSK trellis decoder: one received sample in, best state and its
// latest survivor symbol out, one item per clock cycle sustained while i_ready
// stays high. A sample is taken on i_valid && o_ready; its eight branch
// metrics are computed and written to a two-entry queue in that cycle, and
// the result goes from the queue head to the output register behind o_valid.
// The rate is set by the add-compare-select loop, which updates the four path
// metrics and normalizes them combinationally. o_ready drops only while the
// queue is full, that is while results are being held back by i_ready.
`default_nettype none

`include "tcm_8psk_viterbi_decoder_defines.svh"

module tcm_8psk_viterbi_decoder #(
    parameter int SAMPLE_WIDTH = tcm8_pkg::SAMPLE_WIDTH_DEF,
    parameter int METRIC_WIDTH = tcm8_pkg::METRIC_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [1:0]                          o_decoded_symbol,
    output logic [1:0]                          o_best_state
);
    import tcm8_pkg::*;

    localparam int BM_BUS_W = NUM_POINTS * (SAMPLE_WIDTH + 3);

    logic [BM_BUS_W-1:0] w_bm_in;
    logic [BM_BUS_W-1:0] w_bm_head;
    t_q_stat             w_q_stat;
    logic                w_push;
    logic                w_pop;

    assign o_ready = !w_q_stat.full;
    assign w_push  = i_valid && o_ready;

    tcm8_bm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_sample_i (i_sample_i),
        .i_sample_q (i_sample_q),
        .o_bm       (w_bm_in)
    );

    tcm8_queue #(
        .DATA_W (BM_BUS_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_bm_in),
        .i_pop   (w_pop),
        .o_data  (w_bm_head),
        .o_stat  (w_q_stat)
    );

    tcm8_acs_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .METRIC_WIDTH (METRIC_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_stat         (w_q_stat),
        .i_bm             (w_bm_head),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_decoded_symbol (o_decoded_symbol),
        .o_best_state     (o_best_state)
    );

    `TCM8_ASSERT(a_pop_has_entry, i_clk, i_rst_n, w_pop |-> !w_q_stat.empty)
    `TCM8_ASSERT(a_stat_exclusive, i_clk, i_rst_n, !(w_q_stat.full && w_q_stat.empty))
    `TCM8_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push && w_q_stat.empty, !w_q_stat.empty)

endmodule

`default_nettype wire
